@@ rtl/ssab_pkg.sv @@
package ssab_pkg;

   localparam int MAX_FRAMES = 16;
   localparam int COORD_BITS = 8;
   localparam int FRAME_BITS = $clog2(MAX_FRAMES);
   localparam int DIM_BITS   = COORD_BITS + 1;
   localparam int CNT_BITS   = FRAME_BITS + 1;
   localparam int DIM_MAX    = 1 << COORD_BITS;
   localparam int ALPHA_BITS = 8;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 9;
   localparam int RSP_DATA_BITS = 56;

   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_COUNT  = 2'd2;

   localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = DIM_BITS'(120);
   localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = DIM_BITS'(80);
   localparam logic [CNT_BITS-1:0] FRAME_COUNT_RST  = CNT_BITS'(1);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_FLUSH,
      ST_READ,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] max_y;
      logic [COORD_BITS-1:0] min_y;
      logic [COORD_BITS-1:0] max_x;
      logic [COORD_BITS-1:0] min_x;
   } box_type;

endpackage

@@ rtl/sprite_sheet_alpha_bbox.sv @@
// Pixel path: one alpha word accepted per cycle outside the flush; each opaque pixel is
//    merged into its frame's box entry by a read-modify-write (memory read, then write back).
// After the word that ends the sheet, input pauses; the sequencer steps through FLUSH, then
//    READ and LOAD per frame (one memory read, one output load); LOAD stalls while output is full.
// Input resumes once the last box is loaded.
// Reset: registers to 120 / 80 / 1, counters to zero, per-frame seen bits cleared at once.
module sprite_sheet_alpha_bbox (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ssab_pkg::ALPHA_BITS-1:0]      req_tdata,   // alpha[7:0]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // frame_index[3:0], min_x[11:4], max_x[19:12], min_y[27:20], max_y[35:28],
   // box_width[44:36], box_height[53:45], zero fill[55:54]
   output logic [ssab_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tuser,   // empty_res[0]
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ssab_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ssab_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int CB = ssab_pkg::COORD_BITS;
   localparam int FB = ssab_pkg::FRAME_BITS;
   localparam int DB = ssab_pkg::DIM_BITS;
   localparam int NB = ssab_pkg::CNT_BITS;

   // configuration
   logic [DB-1:0] fw_raw_ff, fh_raw_ff;
   logic [NB-1:0] fc_raw_ff;
   logic [DB-1:0] fw_eff, fh_eff;
   logic [NB-1:0] fc_eff;

   // position counters
   logic [CB-1:0] col_ff, col_in, row_ff, row_in;
   logic [FB-1:0] pos_ff, pos_in;
   logic          col_wrap, pos_wrap, row_wrap, sheet_done, req_accept;

   // update pipeline
   logic          s1_valid_ff;
   logic [FB-1:0] s1_frame_ff;
   logic [CB-1:0] s1_x_ff, s1_y_ff;
   logic          fwd_valid_ff;
   logic [FB-1:0] fwd_addr_ff;
   ssab_pkg::box_type fwd_data_ff;
   ssab_pkg::box_type src_box, merged_box, rd_box;
   logic          seen_cur, wr_en;
   logic [ssab_pkg::MAX_FRAMES-1:0] seen_ff;

   // box memory
   ssab_pkg::box_type mem [ssab_pkg::MAX_FRAMES];
   ssab_pkg::box_type rd_q_ff;
   logic          rd_en;
   logic [FB-1:0] rd_addr;

   // flush sequencer
   ssab_pkg::state_type state_ff, state_in;
   logic [FB-1:0] drain_idx_ff, drain_idx_in;
   logic          load_rsp, clear_seen, drain_last;

   // output register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [ssab_pkg::RSP_DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;
   logic                                 rsp_user_ff, rsp_user_in;
   logic                                 rsp_last_ff, rsp_last_in;
   logic                                 box_seen;
   logic [DB-1:0]                        box_w, box_h;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_raw_ff <= ssab_pkg::FRAME_WIDTH_RST;
         fh_raw_ff <= ssab_pkg::FRAME_HEIGHT_RST;
         fc_raw_ff <= ssab_pkg::FRAME_COUNT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            ssab_pkg::REG_FRAME_WIDTH:  fw_raw_ff <= csr_data;
            ssab_pkg::REG_FRAME_HEIGHT: fh_raw_ff <= csr_data;
            ssab_pkg::REG_FRAME_COUNT:  fc_raw_ff <= csr_data[NB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      fw_eff = (fw_raw_ff == '0) ? DB'(1) :
               (fw_raw_ff > DB'(ssab_pkg::DIM_MAX)) ? DB'(ssab_pkg::DIM_MAX) : fw_raw_ff;
      fh_eff = (fh_raw_ff == '0) ? DB'(1) :
               (fh_raw_ff > DB'(ssab_pkg::DIM_MAX)) ? DB'(ssab_pkg::DIM_MAX) : fh_raw_ff;
      fc_eff = (fc_raw_ff == '0) ? NB'(1) :
               (fc_raw_ff > NB'(ssab_pkg::MAX_FRAMES)) ? NB'(ssab_pkg::MAX_FRAMES) : fc_raw_ff;
   end

   assign req_tready = (state_ff == ssab_pkg::ST_RUN);
   assign req_accept = req_tvalid & req_tready;

   always_comb begin
      col_wrap   = ({1'b0, col_ff} + DB'(1)) >= fw_eff;
      pos_wrap   = ({1'b0, pos_ff} + NB'(1)) >= fc_eff;
      row_wrap   = ({1'b0, row_ff} + DB'(1)) >= fh_eff;
      sheet_done = col_wrap & pos_wrap & row_wrap;
      col_in = col_ff;
      pos_in = pos_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (col_wrap) begin
            col_in = '0;
            if (pos_wrap) begin
               pos_in = '0;
               row_in = row_wrap ? '0 : row_ff + CB'(1);
            end else begin
               pos_in = pos_ff + FB'(1);
            end
         end else begin
            col_in = col_ff + CB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         pos_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         pos_ff <= pos_in;
         row_ff <= row_in;
      end
   end

   // stage 1: capture opaque pixel, memory read issued in parallel
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept && (req_tdata != '0);
      end
      s1_frame_ff <= pos_ff;
      s1_x_ff     <= col_ff;
      s1_y_ff     <= row_ff;
   end

   // stage 2: merge with stored box; forward the write of the previous cycle
   always_comb begin
      seen_cur = seen_ff[s1_frame_ff];
      src_box  = (fwd_valid_ff && (fwd_addr_ff == s1_frame_ff)) ? fwd_data_ff : rd_q_ff;
      merged_box.min_x = (!seen_cur || s1_x_ff < src_box.min_x) ? s1_x_ff : src_box.min_x;
      merged_box.max_x = (!seen_cur || s1_x_ff > src_box.max_x) ? s1_x_ff : src_box.max_x;
      merged_box.min_y = (!seen_cur || s1_y_ff < src_box.min_y) ? s1_y_ff : src_box.min_y;
      merged_box.max_y = (!seen_cur || s1_y_ff > src_box.max_y) ? s1_y_ff : src_box.max_y;
      wr_en = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
         seen_ff      <= '0;
      end else begin
         fwd_valid_ff <= wr_en;
         if (clear_seen) begin
            seen_ff <= '0;
         end else if (wr_en) begin
            seen_ff[s1_frame_ff] <= 1'b1;
         end
      end
      fwd_addr_ff <= s1_frame_ff;
      fwd_data_ff <= merged_box;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s1_frame_ff] <= merged_box;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   // flush sequencer
   assign drain_last = ({1'b0, drain_idx_ff} + NB'(1)) == fc_eff;

   always_comb begin
      state_in     = state_ff;
      drain_idx_in = drain_idx_ff;
      rd_en        = 1'b0;
      rd_addr      = pos_ff;
      load_rsp     = 1'b0;
      clear_seen   = 1'b0;
      case (state_ff)
         ssab_pkg::ST_RUN: begin
            rd_en = req_accept;
            if (req_accept && sheet_done) begin
               state_in = ssab_pkg::ST_FLUSH;
            end
         end
         ssab_pkg::ST_FLUSH: begin
            drain_idx_in = '0;
            state_in     = ssab_pkg::ST_READ;
         end
         ssab_pkg::ST_READ: begin
            rd_en    = 1'b1;
            rd_addr  = drain_idx_ff;
            state_in = ssab_pkg::ST_LOAD;
         end
         ssab_pkg::ST_LOAD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               if (drain_last) begin
                  clear_seen = 1'b1;
                  state_in   = ssab_pkg::ST_RUN;
               end else begin
                  drain_idx_in = drain_idx_ff + FB'(1);
                  state_in     = ssab_pkg::ST_READ;
               end
            end
         end
         default: state_in = ssab_pkg::ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssab_pkg::ST_RUN;
         drain_idx_ff <= '0;
      end else begin
         state_ff     <= state_in;
         drain_idx_ff <= drain_idx_in;
      end
   end

   // output register
   always_comb begin
      rd_box   = rd_q_ff;
      box_seen = seen_ff[drain_idx_ff];
      if (!box_seen) begin
         rd_box = '0;
      end
      box_w = box_seen ? ({1'b0, rd_box.max_x} - {1'b0, rd_box.min_x} + DB'(1)) : '0;
      box_h = box_seen ? ({1'b0, rd_box.max_y} - {1'b0, rd_box.min_y} + DB'(1)) : '0;
      rsp_data_in = {2'b00, box_h, box_w, rd_box.max_y, rd_box.min_y,
                     rd_box.max_x, rd_box.min_x, drain_idx_ff};
      rsp_user_in = !box_seen;
      rsp_last_in = drain_last;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_no_write_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssab_pkg::ST_READ || state_ff == ssab_pkg::ST_LOAD) |-> !wr_en)
      else $error("box write during flush");

   a_seen_cleared: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && drain_last) |=> (seen_ff == '0))
      else $error("seen bits not cleared after flush");

   a_drain_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssab_pkg::ST_LOAD) |-> ({1'b0, drain_idx_ff} < fc_eff))
      else $error("flush index beyond frame count");

   a_last_is_final_frame: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (rsp_last_in == (state_in == ssab_pkg::ST_RUN)))
      else $error("last flag and sequencer exit disagree");

   a_no_input_in_flush: assert property (@(posedge clock) disable iff (reset)
      (req_accept && sheet_done) |=> !req_tready)
      else $error("input accepted after end of sheet");

endmodule

@@ test/sprite_sheet_alpha_bbox_tb.sv @@
module sprite_sheet_alpha_bbox_tb;

   localparam logic [ssab_pkg::CSR_IDX_BITS-1:0] REG_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 2 * ssab_pkg::MAX_FRAMES + 10;
   localparam int ITEM_TARGET = 360;

   typedef struct {
      logic [3:0] frame_index;
      logic [7:0] min_x;
      logic [7:0] max_x;
      logic [7:0] min_y;
      logic [7:0] max_y;
      logic [8:0] box_width;
      logic [8:0] box_height;
      logic       empty_res;
      logic       last;
   } box_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ssab_pkg::ALPHA_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [ssab_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ssab_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [ssab_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   sprite_sheet_alpha_bbox uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial forever #1 clock = ~clock;

   // sheet geometry and per-frame extents as the block should hold them
   logic [8:0] cfg_width = 9'd120;
   logic [8:0] cfg_height = 9'd80;
   logic [4:0] cfg_count = 5'd1;
   int col = 0;
   int frame_pos = 0;
   int row = 0;
   int lo_x [ssab_pkg::MAX_FRAMES];
   int hi_x [ssab_pkg::MAX_FRAMES];
   int lo_y [ssab_pkg::MAX_FRAMES];
   int hi_y [ssab_pkg::MAX_FRAMES];
   bit seen [ssab_pkg::MAX_FRAMES];

   logic [7:0] alpha_pending [$];
   box_result_type boxes_due [$];
   bit offering = 1'b0;
   logic [7:0] offer_alpha = '0;
   int burst_left = 0;
   int gap_left = 0;
   int errors = 0;
   int items_sent = 0;
   int hold_left = 0;
   int holds_asked = 0;
   int holds_done = 0;

   function automatic int eff_size(int v, int hi);
      return (v == 0) ? 1 : ((v > hi) ? hi : v);
   endfunction

   function automatic void track_pixel(logic [7:0] a);
      int fw, fh, fc, f;
      bit sheet_end;
      box_result_type b;
      fw = eff_size(cfg_width, ssab_pkg::DIM_MAX);
      fh = eff_size(cfg_height, ssab_pkg::DIM_MAX);
      fc = eff_size(cfg_count, ssab_pkg::MAX_FRAMES);
      f = frame_pos;
      sheet_end = 1'b0;
      if (a != 0) begin
         if (!seen[f] || col < lo_x[f]) lo_x[f] = col;
         if (!seen[f] || col > hi_x[f]) hi_x[f] = col;
         if (!seen[f] || row < lo_y[f]) lo_y[f] = row;
         if (!seen[f] || row > hi_y[f]) hi_y[f] = row;
         seen[f] = 1'b1;
      end
      if (col + 1 >= fw) begin
         col = 0;
         if (frame_pos + 1 >= fc) begin
            frame_pos = 0;
            if (row + 1 >= fh) begin
               row = 0;
               sheet_end = 1'b1;
            end else begin
               row = (row + 1) & 255;
            end
         end else begin
            frame_pos = (frame_pos + 1) & 15;
         end
      end else begin
         col = (col + 1) & 255;
      end
      if (sheet_end) begin
         for (int k = 0; k < fc; k++) begin
            b.frame_index = 4'(k);
            b.empty_res = !seen[k];
            b.last = (k + 1 == fc);
            if (seen[k]) begin
               b.min_x = 8'(lo_x[k]);
               b.max_x = 8'(hi_x[k]);
               b.min_y = 8'(lo_y[k]);
               b.max_y = 8'(hi_y[k]);
               b.box_width = 9'(hi_x[k] - lo_x[k] + 1);
               b.box_height = 9'(hi_y[k] - lo_y[k] + 1);
            end else begin
               b.min_x = '0;
               b.max_x = '0;
               b.min_y = '0;
               b.max_y = '0;
               b.box_width = '0;
               b.box_height = '0;
            end
            boxes_due.push_back(b);
         end
         for (int k = 0; k < ssab_pkg::MAX_FRAMES; k++) begin
            lo_x[k] = 255;
            hi_x[k] = 0;
            lo_y[k] = 255;
            hi_y[k] = 0;
            seen[k] = 1'b0;
         end
      end
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // pixel driver: bursts of random length, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_pixel(req_tdata);
            items_sent++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (alpha_pending.size() > 0) begin
               offer_alpha = alpha_pending.pop_front();
               offering = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_tvalid <= offering;
         req_tdata <= offer_alpha;
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (holds_done != holds_asked) begin
         holds_done = holds_asked;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   int ready_mode = 0;
   int mode_left = 0;
   always @(posedge clock) begin
      bit ready_now;
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(10, 120);
      end else begin
         mode_left--;
      end
      case (ready_mode)
         2: ready_now = $urandom_range(0, 1);
         3: ready_now = ($urandom_range(0, 3) == 0);
         default: ready_now = 1'b1;
      endcase
      rsp_tready <= (hold_left == 0) && ready_now;
   end

   // box monitor
   always @(posedge clock) begin
      box_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (boxes_due.size() == 0) begin
            $display("%0t: box word with none expected, got %h", $time, rsp_tdata);
            errors++;
         end else begin
            e = boxes_due.pop_front();
            check_field("frame_index", e.frame_index, rsp_tdata[3:0]);
            check_field("min_x", e.min_x, rsp_tdata[11:4]);
            check_field("max_x", e.max_x, rsp_tdata[19:12]);
            check_field("min_y", e.min_y, rsp_tdata[27:20]);
            check_field("max_y", e.max_y, rsp_tdata[35:28]);
            check_field("box_width", e.box_width, rsp_tdata[44:36]);
            check_field("box_height", e.box_height, rsp_tdata[53:45]);
            check_field("empty_res", e.empty_res, rsp_tuser);
            check_field("last", e.last, rsp_tlast);
         end
      end
   end

   task automatic write_reg(logic [ssab_pkg::CSR_IDX_BITS-1:0] idx,
                            logic [ssab_pkg::CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         ssab_pkg::REG_FRAME_WIDTH: cfg_width = val;
         ssab_pkg::REG_FRAME_HEIGHT: cfg_height = val;
         ssab_pkg::REG_FRAME_COUNT: cfg_count = val[4:0];
         default: ;
      endcase
   endtask

   task automatic queue_pixels(int n, int pct);
      for (int i = 0; i < n; i++)
         alpha_pending.push_back(($urandom_range(0, 99) < pct) ?
                                 8'($urandom_range(1, 255)) : 8'h00);
   endtask

   task automatic settle();
      while (alpha_pending.size() != 0 || offering || boxes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [7:0] pattern [18];
      int w, h, c, sheet, n, pct;
      for (int k = 0; k < ssab_pkg::MAX_FRAMES; k++) begin
         lo_x[k] = 255;
         hi_x[k] = 0;
         lo_y[k] = 255;
         hi_y[k] = 0;
         seen[k] = 1'b0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // zero sizes act as one: every pixel is a whole sheet
      write_reg(ssab_pkg::REG_FRAME_WIDTH, 9'd0);
      write_reg(ssab_pkg::REG_FRAME_HEIGHT, 9'd0);
      write_reg(ssab_pkg::REG_FRAME_COUNT, 9'd0);
      alpha_pending.push_back(8'h00);
      alpha_pending.push_back(8'hFF);
      alpha_pending.push_back(8'h01);
      alpha_pending.push_back(8'h80);
      settle();

      // 3x2 frames, three across: empty, single pixel, full
      write_reg(ssab_pkg::REG_FRAME_WIDTH, 9'd3);
      write_reg(ssab_pkg::REG_FRAME_HEIGHT, 9'd2);
      write_reg(ssab_pkg::REG_FRAME_COUNT, 9'd3);
      write_reg(REG_UNUSED, 9'h1AA);
      pattern = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F, 8'h80, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFE, 8'h10};
      foreach (pattern[i]) alpha_pending.push_back(pattern[i]);
      settle();

      // widest frame, saturated from an oversize value
      write_reg(ssab_pkg::REG_FRAME_WIDTH, 9'h1FF);
      write_reg(ssab_pkg::REG_FRAME_HEIGHT, 9'd1);
      write_reg(ssab_pkg::REG_FRAME_COUNT, 9'd1);
      alpha_pending.push_back(8'h01);
      queue_pixels(ssab_pkg::DIM_MAX - 2, 20);
      alpha_pending.push_back(8'hFF);
      settle();

      // most frames; count keeps only its low five bits
      write_reg(ssab_pkg::REG_FRAME_WIDTH, 9'd1);
      write_reg(ssab_pkg::REG_FRAME_HEIGHT, 9'd1);
      write_reg(ssab_pkg::REG_FRAME_COUNT, 9'h1F0);
      queue_pixels(ssab_pkg::MAX_FRAMES, 50);
      settle();

      // receiver holds off while several sheets are offered
      write_reg(ssab_pkg::REG_FRAME_WIDTH, 9'd2);
      write_reg(ssab_pkg::REG_FRAME_HEIGHT, 9'd1);
      write_reg(ssab_pkg::REG_FRAME_COUNT, 9'd4);
      holds_asked++;
      queue_pixels(24, 50);
      settle();

      while (items_sent < ITEM_TARGET) begin
         w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
         h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
         case ($urandom_range(0, 9))
            0: c = 0;
            1: c = 9'h1FF;
            default: c = $urandom_range(1, 16) | ($urandom_range(0, 15) << 5);
         endcase
         write_reg(ssab_pkg::REG_FRAME_WIDTH, 9'(w));
         write_reg(ssab_pkg::REG_FRAME_HEIGHT, 9'(h));
         write_reg(ssab_pkg::REG_FRAME_COUNT, 9'(c));
         if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 9'($urandom_range(0, 511)));
         sheet = eff_size(w, ssab_pkg::DIM_MAX) * eff_size(h, ssab_pkg::DIM_MAX) *
                 eff_size(c & 31, ssab_pkg::MAX_FRAMES);
         n = sheet;
         if ($urandom_range(0, 2) == 0) n += $urandom_range(1, sheet);
         if (n > ITEM_TARGET - items_sent) n = ITEM_TARGET - items_sent;
         case ($urandom_range(0, 4))
            0: pct = 0;
            1: pct = 5;
            2: pct = 25;
            3: pct = 60;
            default: pct = 100;
         endcase
         queue_pixels(n, pct);
         settle();
      end

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/ssab_pkg.sv
rtl/sprite_sheet_alpha_bbox.sv
test/sprite_sheet_alpha_bbox_tb.sv
